FILE: hdl/tnps_pkg.sv
// tnps_pkg: shared widths, codes, config and control structs for the
// tracked nearest point search. no dependencies.
`default_nettype none

package tnps_pkg;

    localparam int POS_W        = 24;
    localparam int DIFF_W       = 25;
    localparam int ID_W         = 16;
    localparam int LEN_W        = 23;
    localparam int SLOT_FIELD_W = 8;
    localparam int MODE_W       = 2;
    localparam int SQ_W         = 49;
    localparam int D2_W         = 50;
    localparam int RAD2_W       = 46;
    localparam int DIST_W       = 25;
    localparam int DIV_STEPS    = 25;
    localparam int DIV_CNT_W    = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 23;

    localparam logic [D2_W-1:0] SQRT_TOP_BIT = D2_W'(1) << 48;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETACH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd6;

    typedef struct packed {
        logic [ID_W-1:0]  window_half_width;
        logic [LEN_W-1:0] switch_radius;
        logic [LEN_W-1:0] detach_radius;
        logic [LEN_W-1:0] box_x;
        logic [LEN_W-1:0] box_y;
        logic [LEN_W-1:0] box_z;
        logic [2:0]       periodic_axes;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [ID_W-1:0]         tag;
    } t_point;

    typedef struct packed {
        logic clr;
        logic load;
        logic query;
        logic scan_start;
        logic rd;
        logic div_start;
        logic fix;
        logic mul;
        logic sum;
        logic acc;
        logic pass2;
        logic sqrt_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last_pt;
        logic div_done;
        logic sqrt_done;
        logic go_global;
        logic found;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/tnps_in_if.sv
// tnps_in_if: input item channel, valid/ready with the item fields
// depends on tnps_pkg
`default_nettype none

interface tnps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tnps_pkg::MODE_W-1:0]          mode;
    logic [tnps_pkg::SLOT_FIELD_W-1:0]    query_slot;
    logic signed [tnps_pkg::POS_W-1:0]    pos_x;
    logic signed [tnps_pkg::POS_W-1:0]    pos_y;
    logic signed [tnps_pkg::POS_W-1:0]    pos_z;
    logic [tnps_pkg::ID_W-1:0]            point_id;

    modport source (output valid, mode, query_slot, pos_x, pos_y, pos_z, point_id,
                    input ready);
    modport sink   (input valid, mode, query_slot, pos_x, pos_y, pos_z, point_id,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/tnps_out_if.sv
// tnps_out_if: result channel, valid/ready with the result fields
// depends on tnps_pkg
`default_nettype none

interface tnps_out_if;
    logic                          valid;
    logic                          ready;
    logic [tnps_pkg::ID_W-1:0]     nearest_id;
    logic [tnps_pkg::DIST_W-1:0]   distance;
    logic                          detached;

    modport source (output valid, nearest_id, distance, detached, input ready);
    modport sink   (input valid, nearest_id, distance, detached, output ready);
endinterface

`default_nettype wire

FILE: hdl/tnps_fold.sv
// tnps_fold: one axis of the minimum image fold, bit-serial remainder
// followed by the half-box correction. depends on tnps_pkg
`default_nettype none

module tnps_fold (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire                                   i_fix,
    input  wire signed [tnps_pkg::DIFF_W-1:0]     i_diff,
    input  wire        [tnps_pkg::LEN_W-1:0]      i_len,
    input  wire                                   i_wrap,
    output logic                                  o_done,
    output logic signed [tnps_pkg::DIFF_W-1:0]    o_fold
);

    logic                                r_neg;
    logic [tnps_pkg::DIFF_W-1:0]         r_mag;
    logic [tnps_pkg::LEN_W-1:0]          r_rem;
    logic [tnps_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic signed [tnps_pkg::DIFF_W-1:0]  r_diff;
    logic signed [tnps_pkg::DIFF_W-1:0]  r_fold;

    logic [tnps_pkg::LEN_W:0]            trial;
    logic [tnps_pkg::LEN_W-1:0]          n_rem;
    logic [tnps_pkg::LEN_W:0]            rem2;
    logic signed [tnps_pkg::DIFF_W-1:0]  n_fold;

    assign o_done = (r_cnt == tnps_pkg::DIV_CNT_W'(tnps_pkg::DIV_STEPS));
    assign o_fold = r_fold;

    // shift in one dividend bit, subtract the box length when it fits
    always_comb begin
        trial = {r_rem, r_mag[tnps_pkg::DIFF_W-1]};
        if (trial >= {1'b0, i_len}) begin
            n_rem = tnps_pkg::LEN_W'(trial - {1'b0, i_len});
        end else begin
            n_rem = trial[tnps_pkg::LEN_W-1:0];
        end
    end

    // negative side mirrors the remainder, then pull into the half box
    always_comb begin
        rem2 = {r_rem, 1'b0};
        if (!i_wrap) begin
            n_fold = r_diff;
        end else if (r_neg && (r_rem != '0)) begin
            if (rem2 < {1'b0, i_len}) begin
                n_fold = -$signed({2'b00, r_rem});
            end else begin
                n_fold = $signed({2'b00, i_len}) - $signed({2'b00, r_rem});
            end
        end else begin
            if (rem2 > {1'b0, i_len}) begin
                n_fold = $signed({2'b00, r_rem}) - $signed({2'b00, i_len});
            end else begin
                n_fold = $signed({2'b00, r_rem});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= tnps_pkg::DIV_CNT_W'(tnps_pkg::DIV_STEPS);
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (!o_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= i_diff;
            r_neg  <= i_diff[tnps_pkg::DIFF_W-1];
            r_mag  <= i_diff[tnps_pkg::DIFF_W-1] ? tnps_pkg::DIFF_W'(-i_diff)
                                                 : tnps_pkg::DIFF_W'(i_diff);
            r_rem  <= '0;
        end else if (!o_done) begin
            r_rem <= n_rem;
            r_mag <= {r_mag[tnps_pkg::DIFF_W-2:0], 1'b0};
        end
        if (i_fix) begin
            r_fold <= n_fold;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tnps_sqrt.sv
// tnps_sqrt: iterative integer square root, two radicand bits per cycle
// depends on tnps_pkg
`default_nettype none

module tnps_sqrt (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [tnps_pkg::D2_W-1:0]        i_value,
    output logic                             o_done,
    output logic [tnps_pkg::DIST_W-1:0]      o_root
);

    logic [tnps_pkg::D2_W-1:0] r_v;
    logic [tnps_pkg::D2_W-1:0] r_res;
    logic [tnps_pkg::D2_W-1:0] r_bit;
    logic [tnps_pkg::D2_W-1:0] trial;

    assign trial  = r_res + r_bit;
    assign o_done = (r_bit == '0);
    assign o_root = r_res[tnps_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= tnps_pkg::SQRT_TOP_BIT;
        end else if (!o_done) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
        end else if (!o_done) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tnps_dp.sv
// tnps_dp: point table, history table, fold/square/compare datapath,
// root unit and result register. depends on tnps_pkg, tnps_fold, tnps_sqrt
`default_nettype none

module tnps_dp #(
    parameter int MAX_POINTS      = 4096,
    parameter int MAX_QUERY_SLOTS = 256
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  tnps_pkg::t_cmd                        i_cmd,
    output tnps_pkg::t_sts                        o_sts,
    input  tnps_pkg::t_cfg                        i_cfg,
    input  wire [tnps_pkg::SLOT_FIELD_W-1:0]      i_slot,
    input  wire signed [tnps_pkg::POS_W-1:0]      i_pos_x,
    input  wire signed [tnps_pkg::POS_W-1:0]      i_pos_y,
    input  wire signed [tnps_pkg::POS_W-1:0]      i_pos_z,
    input  wire [tnps_pkg::ID_W-1:0]              i_point_id,
    input  wire                                   i_out_ready,
    output logic                                  o_out_valid,
    output logic [tnps_pkg::ID_W-1:0]             o_nearest_id,
    output logic [tnps_pkg::DIST_W-1:0]           o_distance,
    output logic                                  o_detached
);

    localparam int PT_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SLOT_W  = (MAX_QUERY_SLOTS > 1) ? $clog2(MAX_QUERY_SLOTS) : 1;
    localparam int SLOT_IN = 2 ** tnps_pkg::SLOT_FIELD_W;

    // slot number folded into the history depth
    logic [SLOT_W-1:0] slot_map [SLOT_IN];
    for (genvar g = 0; g < SLOT_IN; g++) begin : g_slot
        assign slot_map[g] = SLOT_W'(g % MAX_QUERY_SLOTS);
    end

    tnps_pkg::t_point               r_pmem [MAX_POINTS];
    tnps_pkg::t_point               r_rd;
    logic [CNT_W-1:0]               r_count;
    logic [PT_W-1:0]                r_j;

    logic [tnps_pkg::ID_W-1:0]      r_hmem [MAX_QUERY_SLOTS];
    logic [MAX_QUERY_SLOTS-1:0]     r_hvalid;
    logic [tnps_pkg::ID_W-1:0]      r_hist;
    logic                           r_hval;
    logic [SLOT_W-1:0]              r_slot;

    logic signed [tnps_pkg::POS_W-1:0] r_qx, r_qy, r_qz;
    logic                           r_win;
    logic [tnps_pkg::ID_W-1:0]      r_last;
    logic                           r_found;
    logic [tnps_pkg::D2_W-1:0]      r_best;
    logic [tnps_pkg::ID_W-1:0]      r_best_id;
    logic [tnps_pkg::SQ_W-1:0]      r_sqx, r_sqy, r_sqz;
    logic [tnps_pkg::D2_W-1:0]      r_d2;
    logic [tnps_pkg::RAD2_W-1:0]    r_sw2, r_det2;

    logic                           r_out_valid;
    logic [tnps_pkg::ID_W-1:0]      r_out_id;
    logic [tnps_pkg::DIST_W-1:0]    r_out_dist;
    logic                           r_out_det;

    logic signed [tnps_pkg::DIFF_W-1:0] diff_x, diff_y, diff_z;
    logic signed [tnps_pkg::DIFF_W-1:0] fold_x, fold_y, fold_z;
    logic                           done_x, done_y, done_z;
    logic signed [tnps_pkg::D2_W-1:0]   prod_x, prod_y, prod_z;
    logic                           in_window;
    logic                           take;
    logic                           far;
    logic                           sqrt_done;
    logic [tnps_pkg::DIST_W-1:0]    root;
    logic [tnps_pkg::ID_W:0]        win_lo_chk, win_hi;

    assign diff_x = {r_qx[tnps_pkg::POS_W-1], r_qx} - {r_rd.x[tnps_pkg::POS_W-1], r_rd.x};
    assign diff_y = {r_qy[tnps_pkg::POS_W-1], r_qy} - {r_rd.y[tnps_pkg::POS_W-1], r_rd.y};
    assign diff_z = {r_qz[tnps_pkg::POS_W-1], r_qz} - {r_rd.z[tnps_pkg::POS_W-1], r_rd.z};

    tnps_fold u_fold_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start), .i_fix(i_cmd.fix),
        .i_diff(diff_x), .i_len(i_cfg.box_x),
        .i_wrap(i_cfg.periodic_axes[0] && (i_cfg.box_x != '0)),
        .o_done(done_x), .o_fold(fold_x)
    );
    tnps_fold u_fold_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start), .i_fix(i_cmd.fix),
        .i_diff(diff_y), .i_len(i_cfg.box_y),
        .i_wrap(i_cfg.periodic_axes[1] && (i_cfg.box_y != '0)),
        .o_done(done_y), .o_fold(fold_y)
    );
    tnps_fold u_fold_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start), .i_fix(i_cmd.fix),
        .i_diff(diff_z), .i_len(i_cfg.box_z),
        .i_wrap(i_cfg.periodic_axes[2] && (i_cfg.box_z != '0)),
        .o_done(done_z), .o_fold(fold_z)
    );

    tnps_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.sqrt_start),
        .i_value(r_best), .o_done(sqrt_done), .o_root(root)
    );

    assign prod_x = fold_x * fold_x;
    assign prod_y = fold_y * fold_y;
    assign prod_z = fold_z * fold_z;

    // id window test without going negative: tag + w >= last, tag <= last + w
    assign win_lo_chk = {1'b0, r_rd.tag} + {1'b0, i_cfg.window_half_width};
    assign win_hi     = {1'b0, r_last} + {1'b0, i_cfg.window_half_width};
    assign in_window  = !r_win || ((win_lo_chk >= {1'b0, r_last}) &&
                                   ({1'b0, r_rd.tag} <= win_hi));
    assign take       = in_window && (!r_found || (r_d2 < r_best));
    assign far        = r_best > tnps_pkg::D2_W'(r_det2);

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.last_pt   = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign o_sts.div_done  = done_x && done_y && done_z;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.go_global = r_win && r_found && (r_best > tnps_pkg::D2_W'(r_sw2));
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_nearest_id = r_out_id;
    assign o_distance   = r_out_dist;
    assign o_detached   = r_out_det;

    // point table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(MAX_POINTS))) begin
            r_pmem[r_count[PT_W-1:0]] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z,
                                            tag: i_point_id};
        end
        if (i_cmd.rd) begin
            r_rd <= r_pmem[r_j];
        end
    end

    // history table
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hmem[r_slot] <= (r_found && !far) ? r_best_id : '0;
        end
        if (i_cmd.query) begin
            r_hist <= r_hmem[slot_map[i_slot]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hvalid    <= '0;
            r_hval      <= 1'b0;
            r_found     <= 1'b0;
            r_win       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_count <= '0;
            end else if (i_cmd.load && (r_count < CNT_W'(MAX_POINTS))) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.query) begin
                r_hval <= r_hvalid[slot_map[i_slot]];
            end
            if (i_cmd.scan_start) begin
                r_win   <= r_hval && (r_hist != '0) && (i_cfg.window_half_width != '0);
                r_found <= 1'b0;
            end else if (i_cmd.pass2) begin
                r_win   <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.acc && take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_hvalid[r_slot] <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw2  <= i_cfg.switch_radius * i_cfg.switch_radius;
        r_det2 <= i_cfg.detach_radius * i_cfg.detach_radius;
        if (i_cmd.query) begin
            r_qx   <= i_pos_x;
            r_qy   <= i_pos_y;
            r_qz   <= i_pos_z;
            r_slot <= slot_map[i_slot];
        end
        if (i_cmd.scan_start) begin
            r_last <= r_hval ? r_hist : '0;
        end
        if (i_cmd.scan_start || i_cmd.pass2) begin
            r_j <= '0;
        end else if (i_cmd.acc) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.mul) begin
            r_sqx <= prod_x[tnps_pkg::SQ_W-1:0];
            r_sqy <= prod_y[tnps_pkg::SQ_W-1:0];
            r_sqz <= prod_z[tnps_pkg::SQ_W-1:0];
        end
        if (i_cmd.sum) begin
            r_d2 <= {1'b0, r_sqx} + {1'b0, r_sqy} + {1'b0, r_sqz};
        end
        if (i_cmd.acc && take) begin
            r_best    <= r_d2;
            r_best_id <= r_rd.tag;
        end
        if (i_cmd.finish) begin
            r_out_id   <= (r_found && !far) ? r_best_id : '0;
            r_out_dist <= r_found ? root : '0;
            r_out_det  <= r_found && far;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tnps_ctrl.sv
// tnps_ctrl: sequencer for load, clear and the per-point search steps
// depends on tnps_pkg
`default_nettype none

module tnps_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire [tnps_pkg::MODE_W-1:0]       i_mode,
    output logic                             o_in_ready,
    input  tnps_pkg::t_sts                   i_sts,
    output tnps_pkg::t_cmd                   o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_HIST = 11'b000_0000_0010,
        S_RD   = 11'b000_0000_0100,
        S_DIFF = 11'b000_0000_1000,
        S_DIV  = 11'b000_0001_0000,
        S_MUL  = 11'b000_0010_0000,
        S_SUM  = 11'b000_0100_0000,
        S_ACC  = 11'b000_1000_0000,
        S_END  = 11'b001_0000_0000,
        S_SQRT = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        tnps_pkg::MODE_CLEAR: o_cmd.clr = 1'b1;
                        tnps_pkg::MODE_LOAD:  o_cmd.load = 1'b1;
                        tnps_pkg::MODE_QUERY: begin
                            o_cmd.query = 1'b1;
                            n_state     = S_HIST;
                        end
                        default: ;
                    endcase
                end
            end
            S_HIST: begin
                o_cmd.scan_start = 1'b1;
                n_state = i_sts.empty ? S_DONE : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.fix = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last_pt ? S_END : S_RD;
            end
            S_END: begin
                if (i_sts.go_global) begin
                    o_cmd.pass2 = 1'b1;
                    n_state     = S_RD;
                end else if (i_sts.found) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = S_SQRT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tracked_nearest_point_search.sv
// tracked_nearest_point_search: clear and load complete in the idle state, ready again the next cycle
// a query over n > 0 stored points makes one pass over the table, or two when the windowed match
// lies beyond the switch radius, then a square root on a match
// per-point cost is set by the 25-step serial remainder of the periodic fold
// one item at a time; the result register lets the next item in while a result waits
// synchronous active-low reset: empty table, no history, registers at their defaults
`default_nettype none

module tracked_nearest_point_search #(
    parameter int MAX_POINTS      = 4096,
    parameter int MAX_QUERY_SLOTS = 256,
    parameter int FRAC_BITS       = 12
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    tnps_in_if.sink                             i_req,
    tnps_out_if.source                          o_rsp,
    input  wire                                 i_cfg_we,
    input  wire [tnps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [tnps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // register defaults in the fixed-point format
    localparam logic [tnps_pkg::LEN_W-1:0] SWITCH_RST =
        tnps_pkg::LEN_W'((64'd5 << FRAC_BITS) / 2);
    localparam logic [tnps_pkg::LEN_W-1:0] DETACH_RST =
        tnps_pkg::LEN_W'(64'd6 << FRAC_BITS);
    localparam logic [tnps_pkg::LEN_W-1:0] BOX_RST =
        tnps_pkg::LEN_W'(64'd100 << FRAC_BITS);

    tnps_pkg::t_cfg r_cfg;
    tnps_pkg::t_cmd cmd;
    tnps_pkg::t_sts sts;

    // config registers; the user must write them only between transfers, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_half_width <= tnps_pkg::ID_W'(10);
            r_cfg.switch_radius     <= SWITCH_RST;
            r_cfg.detach_radius     <= DETACH_RST;
            r_cfg.box_x             <= BOX_RST;
            r_cfg.box_y             <= BOX_RST;
            r_cfg.box_z             <= BOX_RST;
            r_cfg.periodic_axes     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tnps_pkg::CFG_WINDOW:   r_cfg.window_half_width <= i_cfg_data[15:0];
                tnps_pkg::CFG_SWITCH:   r_cfg.switch_radius     <= i_cfg_data;
                tnps_pkg::CFG_DETACH:   r_cfg.detach_radius     <= i_cfg_data;
                tnps_pkg::CFG_BOX_X:    r_cfg.box_x             <= i_cfg_data;
                tnps_pkg::CFG_BOX_Y:    r_cfg.box_y             <= i_cfg_data;
                tnps_pkg::CFG_BOX_Z:    r_cfg.box_z             <= i_cfg_data;
                tnps_pkg::CFG_PERIODIC: r_cfg.periodic_axes     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // sequencer: one step of the search per state
    tnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_mode     (i_req.mode),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tables, fold, distance, best tracking, root and result transfer
    tnps_dp #(
        .MAX_POINTS      (MAX_POINTS),
        .MAX_QUERY_SLOTS (MAX_QUERY_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg        (r_cfg),
        .i_slot       (i_req.query_slot),
        .i_pos_x      (i_req.pos_x),
        .i_pos_y      (i_req.pos_y),
        .i_pos_z      (i_req.pos_z),
        .i_point_id   (i_req.point_id),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_nearest_id (o_rsp.nearest_id),
        .o_distance   (o_rsp.distance),
        .o_detached   (o_rsp.detached)
    );

    // an input transfer never makes a result appear on the next edge
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !$rose(o_rsp.valid))
        else $error("result appeared right after an input transfer");

    // a detached match always reports id zero
    a_detach_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.detached) |-> (o_rsp.nearest_id == '0))
        else $error("detached result carries an id");

    // a detached match has a squared distance above the squared detach radius, so its distance is nonzero
    a_detach_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.detached) |-> (o_rsp.distance != '0))
        else $error("detached result with zero distance");

endmodule

`default_nettype wire

FILE: bench/tb_tracked_nearest_point_search.sv
// tb_tracked_nearest_point_search: self-checking bench for the tracked nearest point search
// depends on tnps_pkg, tnps_in_if, tnps_out_if and the tracked_nearest_point_search rtl
// a scoreboard class predicts every query result, valid/ready on both sides idle at random
`default_nettype none

module tb_tracked_nearest_point_search;
    timeunit 1ns;
    timeprecision 1ps;

    // mode code the block ignores
    localparam logic [tnps_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 4096;
    localparam int SLOT_COUNT  = 256;
    localparam int ONE         = 4096;    // 1.0 in Q12.12
    // loads complete without leaving the idle state, so a short settle covers anything still in flight
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [tnps_pkg::MODE_W-1:0]       mode;
        logic [tnps_pkg::SLOT_FIELD_W-1:0] slot;
        logic signed [tnps_pkg::POS_W-1:0] x;
        logic signed [tnps_pkg::POS_W-1:0] y;
        logic signed [tnps_pkg::POS_W-1:0] z;
        logic [tnps_pkg::ID_W-1:0]         id;
    } t_search_req;

    typedef struct {
        logic [tnps_pkg::ID_W-1:0]   id;
        logic [tnps_pkg::DIST_W-1:0] distance;
        logic                        det;
    } t_match;

    // mirror of the point table, the slot history and the registers;
    // predicts each query result and checks results in order
    class match_scoreboard;
        logic signed [tnps_pkg::POS_W-1:0] px[TABLE_DEPTH];
        logic signed [tnps_pkg::POS_W-1:0] py[TABLE_DEPTH];
        logic signed [tnps_pkg::POS_W-1:0] pz[TABLE_DEPTH];
        logic [tnps_pkg::ID_W-1:0]         ptag[TABLE_DEPTH];
        logic [tnps_pkg::ID_W-1:0]         history[SLOT_COUNT];
        int unsigned                       count;
        logic [tnps_pkg::ID_W-1:0]         win;
        logic [tnps_pkg::LEN_W-1:0]        sw_rad;
        logic [tnps_pkg::LEN_W-1:0]        det_rad;
        logic [tnps_pkg::LEN_W-1:0]        box[3];
        logic [2:0]                        per;
        t_match                            pending[$];
        int                                errors;
        int                                queries;
        int                                loads;
        int                                settings;

        function new();
            foreach (history[i]) history[i] = '0;
            count    = 0;
            win      = 16'd10;
            sw_rad   = 23'd10240;
            det_rad  = 23'd24576;
            box[0]   = 23'd409600;
            box[1]   = 23'd409600;
            box[2]   = 23'd409600;
            per      = 3'd0;
            errors   = 0;
            queries  = 0;
            loads    = 0;
            settings = 1;
        endfunction

        function void write_reg(logic [tnps_pkg::CFG_IDX_W-1:0] idx,
                                logic [tnps_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                tnps_pkg::CFG_WINDOW:   win     = v[tnps_pkg::ID_W-1:0];
                tnps_pkg::CFG_SWITCH:   sw_rad  = v;
                tnps_pkg::CFG_DETACH:   det_rad = v;
                tnps_pkg::CFG_BOX_X:    box[0]  = v;
                tnps_pkg::CFG_BOX_Y:    box[1]  = v;
                tnps_pkg::CFG_BOX_Z:    box[2]  = v;
                tnps_pkg::CFG_PERIODIC: per     = v[2:0];
                default: ;
            endcase
        endfunction

        // minimum image on a periodic axis, zero length means no wrap
        function longint fold_axis(longint d, int axis);
            longint len;
            longint m;
            if (!per[axis] || box[axis] == '0) return d;
            len = longint'(box[axis]);
            m = d % len;
            if (m < 0) m += len;
            if (2 * m > len) m -= len;
            return m;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] b;
            root = '0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v = v - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        // one pass over the table in load order, strict less keeps the first of a tie
        function bit scan(t_search_req q, bit windowed, longint lo, longint hi,
                          output longint best_d2,
                          output logic [tnps_pkg::ID_W-1:0] best_id);
            bit     hit;
            longint dx;
            longint dy;
            longint dz;
            longint d2;
            hit = 0;
            best_d2 = 0;
            best_id = '0;
            for (int j = 0; j < count; j++) begin
                if (windowed && (longint'(ptag[j]) < lo || longint'(ptag[j]) > hi)) continue;
                dx = fold_axis(longint'(q.x) - longint'(px[j]), 0);
                dy = fold_axis(longint'(q.y) - longint'(py[j]), 1);
                dz = fold_axis(longint'(q.z) - longint'(pz[j]), 2);
                d2 = dx * dx + dy * dy + dz * dz;
                if (!hit || d2 < best_d2) begin
                    hit = 1;
                    best_d2 = d2;
                    best_id = ptag[j];
                end
            end
            return hit;
        endfunction

        function void note_request(t_search_req r);
            logic [tnps_pkg::ID_W-1:0] last;
            logic [tnps_pkg::ID_W-1:0] best_id;
            longint                    best_d2;
            longint                    lo;
            longint                    hi;
            bit                        hit;
            logic [63:0]               root;
            t_match                    m;
            case (r.mode)
                tnps_pkg::MODE_CLEAR: count = 0;
                tnps_pkg::MODE_LOAD: begin
                    loads++;
                    if (count < TABLE_DEPTH) begin
                        px[count]   = r.x;
                        py[count]   = r.y;
                        pz[count]   = r.z;
                        ptag[count] = r.id;
                        count++;
                    end
                end
                tnps_pkg::MODE_QUERY: begin
                    queries++;
                    last = history[r.slot];
                    lo = longint'(last) - longint'(win);
                    hi = longint'(last) + longint'(win);
                    if (last != 0 && win != 0) begin
                        hit = scan(r, 1'b1, lo, hi, best_d2, best_id);
                        // windowed match too far away: fall back to the whole table
                        if (hit && best_d2 > longint'(sw_rad) * longint'(sw_rad))
                            hit = scan(r, 1'b0, lo, hi, best_d2, best_id);
                    end else begin
                        hit = scan(r, 1'b0, lo, hi, best_d2, best_id);
                    end
                    m = '{id: '0, distance: '0, det: 1'b0};
                    if (hit) begin
                        root = floor_sqrt(64'(best_d2));
                        m.distance = (root > 64'd33554431) ? 25'h1FFFFFF
                                                           : root[tnps_pkg::DIST_W-1:0];
                        if (best_d2 > longint'(det_rad) * longint'(det_rad)) m.det = 1'b1;
                        else m.id = best_id;
                    end
                    history[r.slot] = m.id;
                    pending.push_back(m);
                end
                default: ;
            endcase
        endfunction

        function void check_match(t_match got);
            t_match want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: id %0d dist %0d detached %0d",
                         $time, got.id, got.distance, got.det);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.id !== want.id) begin
                $display("%0t: nearest_id mismatch: expected %0d, actual %0d",
                         $time, want.id, got.id);
                errors++;
            end
            if (got.distance !== want.distance) begin
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, want.distance, got.distance);
                errors++;
            end
            if (got.det !== want.det) begin
                $display("%0t: detached mismatch: expected %0d, actual %0d",
                         $time, want.det, got.det);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tnps_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tnps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tnps_in_if  req ();
    tnps_out_if rsp ();

    tracked_nearest_point_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    match_scoreboard board;
    bit tx_burst;    // sender never idles while set
    bit rx_burst;    // receiver never stalls while set

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_search_req make_req(logic [tnps_pkg::MODE_W-1:0] mode, int slot,
                                             int x, int y, int z, int id);
        t_search_req r;
        r.mode = mode;
        r.slot = slot[tnps_pkg::SLOT_FIELD_W-1:0];
        r.x    = x[tnps_pkg::POS_W-1:0];
        r.y    = y[tnps_pkg::POS_W-1:0];
        r.z    = z[tnps_pkg::POS_W-1:0];
        r.id   = id[tnps_pkg::ID_W-1:0];
        return r;
    endfunction

    // one transfer on the request side; called and left at a falling edge
    task automatic send(t_search_req r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.mode       = r.mode;
        req.query_slot = r.slot;
        req.pos_x      = r.x;
        req.pos_y      = r.y;
        req.pos_z      = r.z;
        req.point_id   = r.id;
        req.valid      = 1'b1;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    // registers change only with nothing outstanding
    task automatic write_reg(logic [tnps_pkg::CFG_IDX_W-1:0] idx, int v);
        req.valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v[tnps_pkg::CFG_DATA_W-1:0];
        board.write_reg(idx, v[tnps_pkg::CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic int near_coord(int c, int spread);
        return c + $urandom_range(0, 2 * spread) - spread;
    endfunction

    // small table with clustered ids and positions, then queries around it
    task automatic random_phase(int n_queries);
        int n;
        int base_id;
        int cx;
        int cy;
        int cz;
        int k;
        int slot;
        t_search_req r;
        tx_burst = ($urandom_range(0, 3) == 0);
        send(make_req(tnps_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                      $urandom));
        n = $urandom_range(4, 16);
        base_id = $urandom_range(0, 65535);
        cx = $urandom_range(0, 1 << 22) - (1 << 21);
        cy = $urandom_range(0, 1 << 22) - (1 << 21);
        cz = $urandom_range(0, 1 << 22) - (1 << 21);
        for (int i = 0; i < n; i++) begin
            r = make_req(tnps_pkg::MODE_LOAD, $urandom, near_coord(cx, 16384),
                         near_coord(cy, 16384), near_coord(cz, 16384),
                         base_id + $urandom_range(0, 30));
            if ($urandom_range(0, 9) == 0) r.id = tnps_pkg::ID_W'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                r.x = tnps_pkg::POS_W'($urandom);
                r.y = tnps_pkg::POS_W'($urandom);
                r.z = tnps_pkg::POS_W'($urandom);
            end
            send(r);
        end
        for (int i = 0; i < n_queries; i++) begin
            if ($urandom_range(0, 11) == 0) tx_burst = ~tx_burst;
            slot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
            k = $urandom_range(0, board.count - 1);
            r = make_req(tnps_pkg::MODE_QUERY, slot, near_coord(board.px[k], 24576),
                         near_coord(board.py[k], 24576), near_coord(board.pz[k], 24576),
                         $urandom);
            if ($urandom_range(0, 7) == 0) begin
                r.x = tnps_pkg::POS_W'($urandom);
                r.y = tnps_pkg::POS_W'($urandom);
                r.z = tnps_pkg::POS_W'($urandom);
            end
            send(r);
            // occasional stray load or unused item between queries
            if ($urandom_range(0, 9) == 0)
                send(make_req(tnps_pkg::MODE_LOAD, $urandom, near_coord(cx, 16384),
                              near_coord(cy, 16384), near_coord(cz, 16384),
                              base_id + $urandom_range(0, 30)));
            else if ($urandom_range(0, 19) == 0)
                send(make_req(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    // result side: random stalls, each transfer checked at the rising edge
    initial begin
        t_match got;
        int stall;
        rsp.ready = 1'b0;
        rx_burst  = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (rsp.valid !== 1'b1);
            got.id       = rsp.nearest_id;
            got.distance = rsp.distance;
            got.det      = rsp.detached;
            board.check_match(got);
            @(negedge i_clk);
        end
    end

    initial begin
        board = new();
        tx_burst       = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req.valid      = 1'b0;
        req.mode       = '0;
        req.query_slot = '0;
        req.pos_x      = '0;
        req.pos_y      = '0;
        req.pos_z      = '0;
        req.point_id   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part under reset registers
        // query on an empty table: no match at all
        send(make_req(tnps_pkg::MODE_QUERY, 0, 0, 0, 0, 0));
        send(make_req(MODE_UNUSED, 255, -1, -1, -1, 65535));
        send(make_req(tnps_pkg::MODE_LOAD, 0, 0, 0, 0, 1));
        send(make_req(tnps_pkg::MODE_LOAD, 0, 2 * ONE, 0, 0, 2));
        send(make_req(tnps_pkg::MODE_LOAD, 0, 10 * ONE, 0, 0, 100));
        send(make_req(tnps_pkg::MODE_LOAD, 0, 0, -20 * ONE, 0, 0));    // id zero point
        send(make_req(tnps_pkg::MODE_LOAD, 0, 8388607, 8388607, 8388607, 65535));
        send(make_req(tnps_pkg::MODE_LOAD, 0, -8388608, -8388608, -8388608, 50));
        // equidistant from ids 1 and 2: the earlier load wins
        send(make_req(tnps_pkg::MODE_QUERY, 3, ONE, 0, 0, 0));
        // windowed hit beyond switch radius, global search, then beyond detach radius
        send(make_req(tnps_pkg::MODE_QUERY, 3, 0, 10 * ONE, 0, 0));
        send(make_req(tnps_pkg::MODE_QUERY, 4, 0, 0, 0, 0));
        // window holds ids 0..2 only, switch to global finds id 100
        send(make_req(tnps_pkg::MODE_QUERY, 4, 10 * ONE, 0, 0, 0));
        // match on id zero leaves the slot with no history
        send(make_req(tnps_pkg::MODE_QUERY, 5, 0, -20 * ONE, ONE, 0));
        send(make_req(tnps_pkg::MODE_QUERY, 255, 8388607, 8388607, 8388600, 0));
        send(make_req(tnps_pkg::MODE_QUERY, 200, -8388608, -8388608, -8388608, 0));
        send(make_req(tnps_pkg::MODE_QUERY, 6, 8388607, -8388608, 8388607, 0));
        send(make_req(tnps_pkg::MODE_CLEAR, 0, 0, 0, 0, 0));
        send(make_req(tnps_pkg::MODE_LOAD, 0, 0, 0, 0, 1));
        // slot 4 remembers id 100, its window is now empty: no match, no fallback
        send(make_req(tnps_pkg::MODE_QUERY, 4, 0, 0, 0, 0));
        send(make_req(tnps_pkg::MODE_QUERY, 4, 0, 0, 0, 0));
        random_phase(8);

        // no window, huge radii, wrap on all axes, an odd length on y, zero length on z
        write_reg(tnps_pkg::CFG_WINDOW, 0);
        write_reg(tnps_pkg::CFG_SWITCH, 8388607);
        write_reg(tnps_pkg::CFG_DETACH, 8388607);
        write_reg(tnps_pkg::CFG_BOX_X, 40960);
        write_reg(tnps_pkg::CFG_BOX_Y, 8388607);
        write_reg(tnps_pkg::CFG_BOX_Z, 0);
        write_reg(tnps_pkg::CFG_PERIODIC, 7);
        board.settings++;
        random_phase(8);

        // widest window, radii of one, unit box on x
        write_reg(tnps_pkg::CFG_WINDOW, 65535);
        write_reg(tnps_pkg::CFG_SWITCH, 1);
        write_reg(tnps_pkg::CFG_DETACH, 1);
        write_reg(tnps_pkg::CFG_BOX_X, 1);
        write_reg(tnps_pkg::CFG_BOX_Y, 16384);
        write_reg(tnps_pkg::CFG_BOX_Z, 409600);
        write_reg(tnps_pkg::CFG_PERIODIC, 5);
        board.settings++;
        random_phase(8);

        // narrow window with moderate radii, wrap on y only
        write_reg(tnps_pkg::CFG_WINDOW, 3);
        write_reg(tnps_pkg::CFG_SWITCH, 20480);
        write_reg(tnps_pkg::CFG_DETACH, 30000);
        write_reg(tnps_pkg::CFG_BOX_Y, 61440);
        write_reg(tnps_pkg::CFG_PERIODIC, 2);
        board.settings++;
        random_phase(8);

        req.valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("run covered %0d queries and %0d point loads under %0d register settings",
                 board.queries, board.loads, board.settings);
        $display("including empty tables and windows, ties, id zero and periodic wrap");
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/tnps_pkg.sv
hdl/tnps_in_if.sv
hdl/tnps_out_if.sv
hdl/tnps_fold.sv
hdl/tnps_sqrt.sv
hdl/tnps_dp.sv
hdl/tnps_ctrl.sv
hdl/tracked_nearest_point_search.sv
bench/tb_tracked_nearest_point_search.sv
